@@ src/msam_pkg.sv @@
// Shared types and constants of the audio mixer.
package msam_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned MaxSrc   = 8;
  localparam int unsigned MaskW    = 8;
  // Room for the sum of up to eight full-scale samples.
  localparam int unsigned SumW     = 19;
  localparam int unsigned GainW    = 17;
  localparam int unsigned CountW   = 4;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] CFG_MIX_MODE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_VOLUME   = 2'd1;

  localparam logic [GainW-1:0] UNITY_GAIN = 17'h10000;

  typedef enum logic [1:0] {
    MIX_LEFT   = 2'd0,
    MIX_RIGHT  = 2'd1,
    MIX_STEREO = 2'd2,
    MIX_ALT    = 2'd3
  } mix_mode_e;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [SumW-1:0]    sum_t;

endpackage

@@ src/multi_source_audio_mixer_unit.sv @@
// Top level of the multi-source saturating PCM audio mixer.
//
// Input beat: source_sample_N_i and active_mask_i are taken at a rising edge
// with start high and busy low. busy stays low, so a beat can be given in
// every cycle. Mask bits at or above SOURCES are ignored.
// Result: left_out_o, right_out_o, active_count_o and all_silent_o are valid
// for exactly one cycle while done_o is high. A taken beat passes through
// the input register and then the result register, which lie around the
// adder tree, clamp and gain multiply; one result per cycle is sustained,
// as busy never stalls the input.
// The receiver cannot stall; results are not held.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i.
// Index 0 is mix_mode, index 1 is volume_gain; other indexes are dropped.
// Write configuration only while no beat is in flight.
// Reset (rst_ni low, async): mix_mode goes to alternating, volume to unity,
// and the pipeline is emptied.
module multi_source_audio_mixer_unit import msam_pkg::*; #(
  parameter int unsigned SOURCES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sample_t             source_sample_0_i,
  input  sample_t             source_sample_1_i,
  input  sample_t             source_sample_2_i,
  input  sample_t             source_sample_3_i,
  input  sample_t             source_sample_4_i,
  input  sample_t             source_sample_5_i,
  input  sample_t             source_sample_6_i,
  input  sample_t             source_sample_7_i,
  input  logic [MaskW-1:0]    active_mask_i,
  output logic                done_o,
  output sample_t             left_out_o,
  output sample_t             right_out_o,
  output logic [CountW-1:0]   active_count_o,
  output logic                all_silent_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  mix_mode_e          mix_mode_q;
  logic [GainW-1:0]   gain_q;

  sample_t            samp_in [MaxSrc];
  logic [MaxSrc-1:0]  lane_en;
  sample_t            samp_q  [MaxSrc];
  logic [MaxSrc-1:0]  mask_q;
  logic               in_vld_q;

  sum_t               all_sum, even_sum, odd_sum;
  sum_t               left_sum, right_sum;
  sample_t            left_d, right_d;
  logic [CountW-1:0]  count_d;

  logic               out_vld_q;
  sample_t            left_q, right_q;
  logic [CountW-1:0]  count_q;

  logic               accept;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_mode_q <= MIX_ALT;
      gain_q     <= UNITY_GAIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIX_MODE: mix_mode_q <= mix_mode_e'(cfg_data_i[1:0]);
        CFG_VOLUME:   gain_q     <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  assign samp_in[0] = source_sample_0_i;
  assign samp_in[1] = source_sample_1_i;
  assign samp_in[2] = source_sample_2_i;
  assign samp_in[3] = source_sample_3_i;
  assign samp_in[4] = source_sample_4_i;
  assign samp_in[5] = source_sample_5_i;
  assign samp_in[6] = source_sample_6_i;
  assign samp_in[7] = source_sample_7_i;

  for (genvar i = 0; i < MaxSrc; i++) begin : g_lane
    assign lane_en[i] = (i < SOURCES);
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      samp_q <= samp_in;
      mask_q <= active_mask_i[MaxSrc-1:0] & lane_en;
    end
  end

  always_comb begin
    even_sum = '0;
    odd_sum  = '0;
    for (int i = 0; i < MaxSrc; i++) begin
      if (mask_q[i]) begin
        if (i % 2 == 1) begin
          odd_sum  = odd_sum + SumW'(samp_q[i]);
        end else begin
          even_sum = even_sum + SumW'(samp_q[i]);
        end
      end
    end
    all_sum = even_sum + odd_sum;
  end

  always_comb begin
    unique case (mix_mode_q)
      MIX_LEFT: begin
        left_sum  = all_sum;
        right_sum = '0;
      end
      MIX_RIGHT: begin
        left_sum  = '0;
        right_sum = all_sum;
      end
      MIX_STEREO: begin
        left_sum  = all_sum;
        right_sum = all_sum;
      end
      default: begin
        left_sum  = even_sum;
        right_sum = odd_sum;
      end
    endcase
  end

  assign count_d = CountW'($countones(mask_q));

  msam_gain u_gain_left (
    .sum_i    (left_sum),
    .gain_i   (gain_q),
    .sample_o (left_d)
  );

  msam_gain u_gain_right (
    .sum_i    (right_sum),
    .gain_i   (gain_q),
    .sample_o (right_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      count_q <= count_d;
    end
  end

  assign done_o         = out_vld_q;
  assign left_out_o     = left_q;
  assign right_out_o    = right_q;
  assign active_count_o = count_q;
  assign all_silent_o   = (count_q == '0);

endmodule

@@ src/msam_gain.sv @@
// Saturation to 16 bits and Q1.16 volume scaling of one channel.
module msam_gain import msam_pkg::*; (
  input  sum_t             sum_i,
  input  logic [GainW-1:0] gain_i,
  output sample_t          sample_o
);

  localparam sum_t SatMax = SumW'(32767);
  localparam sum_t SatMin = -SumW'(32768);

  sample_t                sat;
  logic [SampleW:0]       sat_ext;
  logic [SampleW:0]       mag;
  logic [SampleW+GainW-1:0] prod;
  logic [SampleW-1:0]     scaled;

  always_comb begin
    if (sum_i > SatMax) begin
      sat = sample_t'(SatMax);
    end else if (sum_i < SatMin) begin
      sat = sample_t'(SatMin);
    end else begin
      sat = sum_i[SampleW-1:0];
    end
  end

  // Scale the magnitude so the result truncates toward zero.
  assign sat_ext = {sat[SampleW-1], sat};
  assign mag     = sat[SampleW-1] ? (SampleW+1)'(-sat_ext) : sat_ext;
  assign prod    = mag * gain_i[GainW-2:0];
  // Gain below unity keeps the scaled magnitude below full scale.
  assign scaled  = prod[SampleW+GainW-2:GainW-1];

  always_comb begin
    if (gain_i >= UNITY_GAIN) begin
      sample_o = sat;
    end else if (sat[SampleW-1]) begin
      sample_o = sample_t'(-scaled);
    end else begin
      sample_o = sample_t'(scaled);
    end
  end

endmodule
